/* rtl/rfr_pkg.sv */
// Shared types, codes and the byte-wide CRC-16 function for the response
// frame receiver. No dependencies.

package rfr_pkg;

	// Opcode of an input transaction
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	// Result kind
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// End-of-frame status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_CRC_BAD   = 3'd1;
	localparam logic [2:0] ST_WRONGTYPE = 3'd2;
	localparam logic [2:0] ST_TRUNC     = 3'd3;
	localparam logic [2:0] ST_SHORT     = 3'd4;

	localparam logic [15:0] CRC_POLY     = 16'h8005;
	localparam logic [15:0] HEADER_BYTES = 16'd5;

	// One result transaction
	typedef struct packed {
		logic        kind;
		logic [7:0]  frame_id;
		logic [7:0]  header_flags;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic [2:0]  frame_status;
	} rfr_result_t;

	// CRC-16, poly 0x8005, MSB first, one byte unrolled over eight bit steps
	function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/rfr_deframer.sv */
// Frame parser state machine with running CRC for the response frame receiver.
// Depends on rfr_pkg.

module rfr_deframer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 opcode,
	input  logic [7:0]           data_byte,
	input  logic [7:0]           response_type,
	output logic                 emit,
	output rfr_pkg::rfr_result_t result
);
	import rfr_pkg::*;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_ID      = 3'd1;
	localparam logic [2:0] PH_FLAGS   = 3'd2;
	localparam logic [2:0] PH_LEN_HI  = 3'd3;
	localparam logic [2:0] PH_LEN_LO  = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;
	localparam logic [2:0] PH_CRC     = 3'd6;
	localparam logic [2:0] PH_DRAIN   = 3'd7;

	logic [2:0]  phase_q,    phase_d;
	logic [15:0] crc_q,      crc_d;
	logic [7:0]  id_q,       id_d;
	logic [7:0]  flags_q,    flags_d;
	logic [15:0] plen_q,     plen_d;
	logic [15:0] count_q,    count_d;
	logic [7:0]  high_q,     high_d;

	logic [15:0] crc_next;
	logic [15:0] word;
	logic [15:0] count_inc;

	assign crc_next  = crc16_byte((phase_q == PH_IDLE) ? 16'h0000 : crc_q, data_byte);
	assign word      = {high_q, data_byte};
	assign count_inc = count_q + 16'd1;

	// Next state and result for one transaction
	always_comb begin
		phase_d = phase_q;
		crc_d   = crc_q;
		id_d    = id_q;
		flags_d = flags_q;
		plen_d  = plen_q;
		count_d = count_q;
		high_d  = high_q;
		emit    = 1'b0;
		result  = '{kind: KIND_STATUS, frame_id: id_q, header_flags: flags_q,
			payload_byte: 8'h00, payload_index: 16'h0000, frame_status: ST_OK};

		if (step) begin
			if (opcode == OP_TIMEOUT) begin
				// a timeout inside a frame truncates it; drain just ends
				if (phase_q != PH_IDLE) begin
					emit = (phase_q != PH_DRAIN);
					result.frame_status = ST_TRUNC;
					phase_d = PH_IDLE;
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						id_d    = 8'h00;
						flags_d = 8'h00;
						crc_d   = crc_next;
						if (data_byte != response_type) begin
							emit = 1'b1;
							result.frame_id     = 8'h00;
							result.header_flags = 8'h00;
							result.frame_status = ST_WRONGTYPE;
						end else begin
							phase_d = PH_ID;
						end
					end
					PH_ID: begin
						id_d    = data_byte;
						crc_d   = crc_next;
						phase_d = PH_FLAGS;
					end
					PH_FLAGS: begin
						flags_d = data_byte;
						crc_d   = crc_next;
						phase_d = PH_LEN_HI;
					end
					PH_LEN_HI: begin
						high_d  = data_byte;
						crc_d   = crc_next;
						phase_d = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						crc_d = crc_next;
						if (word < HEADER_BYTES) begin
							emit = 1'b1;
							result.frame_status = ST_SHORT;
							phase_d = PH_IDLE;
						end else begin
							plen_d  = word - HEADER_BYTES;
							count_d = 16'h0000;
							phase_d = (word == HEADER_BYTES) ? PH_CRC : PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						crc_d = crc_next;
						emit  = 1'b1;
						result.kind          = KIND_PAYLOAD;
						result.payload_byte  = data_byte;
						result.payload_index = count_q;
						count_d = count_inc;
						if (count_inc == plen_q) begin
							phase_d = PH_CRC;
						end
					end
					PH_CRC: begin
						// count == length: CRC high byte pending, else low byte
						if (count_q == plen_q) begin
							high_d  = data_byte;
							count_d = count_inc;
						end else begin
							emit = 1'b1;
							if (word == crc_q) begin
								result.frame_status = ST_OK;
								phase_d = PH_IDLE;
							end else begin
								result.frame_status = ST_CRC_BAD;
								phase_d = PH_DRAIN;
							end
						end
					end
					PH_DRAIN: begin
						phase_d = PH_DRAIN;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			crc_q   <= 16'h0000;
			id_q    <= 8'h00;
			flags_q <= 8'h00;
			plen_q  <= 16'h0000;
			count_q <= 16'h0000;
			high_q  <= 8'h00;
		end else begin
			phase_q <= phase_d;
			crc_q   <= crc_d;
			id_q    <= id_d;
			flags_q <= flags_d;
			plen_q  <= plen_d;
			count_q <= count_d;
			high_q  <= high_d;
		end
	end

	// Payload index always stays below the payload length
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> count_q < plen_q)
		else $error("payload count reached length inside payload");

	// A CRC mismatch puts the parser into drain
	assert property (@(posedge clk) disable iff (!arst_n)
		emit && result.kind == KIND_STATUS && result.frame_status == ST_CRC_BAD
		|=> phase_q == PH_DRAIN)
		else $error("crc mismatch did not enter drain");

	// Nothing is emitted while draining
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DRAIN |-> !emit)
		else $error("result emitted during drain");

endmodule

/* rtl/response_frame_receiver_crc16_top.sv */
// Top level of the response frame receiver: input register, deframer and
// output register. Depends on rfr_pkg and rfr_deframer.
//
// Usage:
//   Input channel (in_valid/in_ready, opcode, data_byte): one transaction per
//   received byte (opcode 0) or line timeout (opcode 1).
//   Output channel (out_valid/out_ready, result fields): payload bytes with
//   their index, and one status transaction at the end of every frame.
//   cfg_wr_en/cfg_wr_data write the expected response type byte; write it
//   only while no transaction is in flight.
// Path: an accepted input waits in the input register; the parser works from
//   it, and the output register captures its result when the transaction
//   advances (the output register is free or being read).
// Throughput: one input transaction per cycle while the output is not stalled;
//   the whole CRC byte update and the parser step fit between the input and output registers.
// Reset: arst_n clears both pipeline registers, the parser (idle, waiting for
//   a type byte), the CRC and the response type register (0).
// Stall: while out_ready is low and a result is held, the input register
//   keeps its transaction and in_ready drops; nothing is lost or repeated.

module response_frame_receiver_crc16_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  frame_id,
	output logic [7:0]  header_flags,
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_index,
	output logic [2:0]  frame_status
);
	import rfr_pkg::*;

	logic        resp_type_q;
	logic [7:0]  resp_type_val_q;
	logic        valid_s1;
	logic        opcode_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        emit;
	rfr_result_t result;
	logic        out_valid_q;
	rfr_result_t out_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_type_val_q <= 8'h00;
			resp_type_q     <= 1'b0;
		end else if (cfg_wr_en) begin
			resp_type_val_q <= cfg_wr_data;
			resp_type_q     <= 1'b1;
		end
	end

	// The held transaction moves on when the output register is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			byte_s1   <= data_byte;
		end
	end

	rfr_deframer u_deframer (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.opcode        (opcode_s1),
		.data_byte     (byte_s1),
		.response_type (resp_type_val_q),
		.emit          (emit),
		.result        (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = out_q.kind;
	assign frame_id      = out_q.frame_id;
	assign header_flags  = out_q.header_flags;
	assign payload_byte  = out_q.payload_byte;
	assign payload_index = out_q.payload_index;
	assign frame_status  = out_q.frame_status;

	// Payload transactions carry status ok
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_PAYLOAD |-> out_q.frame_status == ST_OK)
		else $error("payload transaction with nonzero status");

	// Status transactions carry zero payload fields
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_STATUS
		|-> out_q.payload_index == 16'h0000 && out_q.payload_byte == 8'h00)
		else $error("status transaction with payload fields set");

	// A held transaction behind a stalled output blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready && !advance)
		else $error("input taken while output stalled");

	// Once written, the type register remains marked written
	assert property (@(posedge clk) disable iff (!arst_n)
		resp_type_q |=> resp_type_q)
		else $error("type register write mark lost");

endmodule
